// ===== hw/rtl/p1305_pkg.sv =====
// Shared types and constants for the Poly1305 MAC core.
package p1305_pkg;

  localparam int LIMB_W = 26;               // accumulator limb width
  localparam int A_W    = LIMB_W + 1;       // h + m limb
  localparam int B_W    = LIMB_W + 3;       // r limb times five
  localparam int P_W    = A_W + B_W;        // one limb product
  localparam int D_W    = 60;               // column sum plus carries
  localparam int NLIMB  = 5;
  localparam int CNT_W  = 5;

  localparam logic [63:0] CLAMP_LOW  = 64'h0ffffffc0fffffff;
  localparam logic [63:0] CLAMP_HIGH = 64'h0ffffffc0ffffffc;

  localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(NLIMB * NLIMB);  // drain cycle
  localparam logic [CNT_W-1:0] CARRY_LAST = CNT_W'(3 * NLIMB - 1);

  typedef enum logic [1:0] {
    REG_R_LOW  = 2'd0,
    REG_R_HIGH = 2'd1,
    REG_S_LOW  = 2'd2,
    REG_S_HIGH = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_CARRY = 5'b00100,
    S_RED   = 5'b01000,
    S_TAG   = 5'b10000
  } state_t;

  // Travels alongside a product through the multiplier register.
  typedef struct packed {
    logic vld;
    logic first;      // first term of a column
    logic last_term;  // last term of a column
  } mul_tag_t;

endpackage

// ===== hw/rtl/poly1305_mac_core.sv =====
// Poly1305 MAC core (RFC 8439 arithmetic): one 16-byte block per input word, the tag
// comes out after a word marked tlast. A block with data is worked through before the next word is
// accepted: 25 limb products issued through one shared 27x29 multiplier, then a drain, then
// 15 single-limb carry steps. A last word then goes on to the final reduction and the add of s;
// a last word with byte count zero goes straight to the reduction and the add of s.
// The tag sits in an output register, so the next message may start while it waits.
module poly1305_mac_core
  import p1305_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // block_low[63:0], block_high[127:64], byte_count[132:128]
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // tag_low[63:0], tag_high[127:64]
);

  logic [63:0]       r_low_r, r_high_r, s_low_r, s_high_r;
  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [2:0]        o_r, t_r, lidx_r;
  logic              last_r;
  logic [LIMB_W-1:0] h_r [NLIMB];
  logic [A_W-1:0]    ma_r [NLIMB];
  logic [D_W-1:0]    d_r [NLIMB];
  logic [D_W-1:0]    sum_r;
  logic [127:0]      hf_r;
  logic              out_tvalid_r;
  logic [127:0]      out_data_r;

  // ---- clamped r limbs and r*5 ----
  logic [127:0]      rc;
  logic [LIMB_W-1:0] rl [NLIMB];
  logic [B_W-1:0]    r5 [NLIMB];

  assign rc = {r_high_r & CLAMP_HIGH, r_low_r & CLAMP_LOW};

  always_comb begin
    for (int i = 0; i < NLIMB - 1; i++) begin
      rl[i] = rc[i*LIMB_W +: LIMB_W];
    end
    rl[NLIMB-1] = {2'b00, rc[127:104]};
    for (int i = 0; i < NLIMB; i++) begin
      r5[i] = {rl[i], 2'b00} + B_W'(rl[i]);
    end
  end

  // ---- input block padding and limb split ----
  logic [4:0]        n;
  logic [6:0]        shamt;
  logic [127:0]      blk, pad1, data;
  logic [128:0]      mv;
  logic [LIMB_W-1:0] ml [NLIMB];
  logic              accept;

  assign accept = in_tvalid && in_tready;
  assign blk    = in_tdata[127:0];
  assign n      = (in_tdata[132:128] > 5'd16) ? 5'd16 : in_tdata[132:128];
  assign shamt  = {n[3:0], 3'b000};
  assign pad1   = 128'd1 << shamt;
  assign data   = n[4] ? blk : ((blk & (pad1 - 128'd1)) | pad1);
  assign mv     = {n[4], data};

  always_comb begin
    for (int i = 0; i < NLIMB - 1; i++) begin
      ml[i] = mv[i*LIMB_W +: LIMB_W];
    end
    ml[NLIMB-1] = {1'b0, mv[128:104]};
  end

  // ---- multiplier operand select: column o, term t ----
  logic [2:0]     j;
  logic [B_W-1:0] b_sel;
  logic [A_W-1:0] a_sel;
  mul_tag_t       tag_in, mtag;
  logic [P_W-1:0] prod;
  logic           issue;

  assign issue = (state_r == S_MUL) && (cnt_r < MUL_LAST);
  assign j     = (o_r >= t_r) ? (o_r - t_r) : (o_r + 3'd5 - t_r);
  assign a_sel = ma_r[t_r];
  assign b_sel = (t_r > o_r) ? r5[j] : B_W'(rl[j]);

  assign tag_in.vld       = issue;
  assign tag_in.first     = (t_r == 3'd0);
  assign tag_in.last_term = (t_r == 3'd4);

  p1305_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .a       (a_sel),
    .b       (b_sel),
    .tag_in  (tag_in),
    .prod    (prod),
    .tag_out (mtag)
  );

  logic [D_W-1:0] sum_nxt;
  assign sum_nxt = mtag.first ? D_W'(prod) : sum_r + D_W'(prod);

  // ---- one carry step on the limb at the head, then rotate ----
  logic [D_W-1:0] carry;
  logic [D_W-1:0] nd [NLIMB];

  assign carry = d_r[0] >> LIMB_W;

  always_comb begin
    nd[0] = d_r[1] + ((lidx_r == 3'd4) ? ((carry << 2) + carry) : carry);
    for (int i = 1; i < NLIMB - 1; i++) begin
      nd[i] = d_r[i+1];
    end
    nd[NLIMB-1] = {{(D_W-LIMB_W){1'b0}}, d_r[0][LIMB_W-1:0]};
  end

  // ---- final reduction ----
  logic [129:0] hv;
  logic [130:0] g;
  logic         out_free;

  assign hv       = {h_r[4], h_r[3], h_r[2], h_r[1], h_r[0]};
  assign g        = {1'b0, hv} + 131'd5;
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_low_r      <= '0;
      r_high_r     <= '0;
      s_low_r      <= '0;
      s_high_r     <= '0;
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      o_r          <= '0;
      t_r          <= '0;
      lidx_r       <= '0;
      last_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NLIMB; i++) begin
        h_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_R_LOW:  r_low_r  <= cfg_wdata;
          REG_R_HIGH: r_high_r <= cfg_wdata;
          REG_S_LOW:  s_low_r  <= cfg_wdata;
          REG_S_HIGH: s_high_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (state_r == S_TAG && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            last_r <= in_tlast;
            cnt_r  <= '0;
            o_r    <= '0;
            t_r    <= '0;
            if (n != 5'd0) begin
              state_r <= S_MUL;
            end else if (in_tlast) begin
              state_r <= S_RED;
            end
          end
        end
        S_MUL: begin
          if (issue) begin
            if (t_r == 3'd4) begin
              t_r <= '0;
              o_r <= o_r + 1'b1;
            end else begin
              t_r <= t_r + 1'b1;
            end
          end
          if (cnt_r == MUL_LAST) begin
            state_r <= S_CARRY;
            cnt_r   <= '0;
            lidx_r  <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_CARRY: begin
          cnt_r  <= cnt_r + 1'b1;
          lidx_r <= (lidx_r == 3'd4) ? 3'd0 : lidx_r + 1'b1;
          if (cnt_r == CARRY_LAST) begin
            for (int i = 0; i < NLIMB; i++) begin
              h_r[i] <= nd[i][LIMB_W-1:0];
            end
            state_r <= last_r ? S_RED : S_IDLE;
          end
        end
        S_RED: begin
          state_r <= S_TAG;
        end
        S_TAG: begin
          if (out_free) begin
            for (int i = 0; i < NLIMB; i++) begin
              h_r[i] <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NLIMB; i++) begin
        ma_r[i] <= A_W'(ml[i]) + A_W'(h_r[i]);
      end
    end
    if (mtag.vld) begin
      sum_r <= sum_nxt;
    end
    if (mtag.vld && mtag.last_term) begin
      for (int i = 0; i < NLIMB - 1; i++) begin
        d_r[i] <= d_r[i+1];
      end
      d_r[NLIMB-1] <= sum_nxt;
    end else if (state_r == S_CARRY) begin
      for (int i = 0; i < NLIMB; i++) begin
        d_r[i] <= nd[i];
      end
    end
    if (state_r == S_RED) begin
      hf_r <= g[130] ? g[127:0] : hv[127:0];
    end
    if (state_r == S_TAG && out_free) begin
      out_data_r <= hf_r + {s_high_r, s_low_r};
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // no product may be in flight outside the multiply phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MUL) |-> !mtag.vld)
    else $error("product outside multiply phase");

  // a tag goes out together with the accumulator clear
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> (h_r[0] == '0 && h_r[1] == '0 && h_r[2] == '0 &&
                             h_r[3] == '0 && h_r[4] == '0))
    else $error("accumulator not cleared with tag");

  // carry steps only start once the last column has landed
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && cnt_r == MUL_LAST) |-> (mtag.vld && mtag.last_term))
    else $error("last column missing at end of multiply");
`endif

endmodule

// ===== hw/rtl/p1305_mul.sv =====
// Shared registered limb multiplier with a sideband tag.
module p1305_mul
  import p1305_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  input  mul_tag_t       tag_in,
  output logic [P_W-1:0] prod,
  output mul_tag_t       tag_out
);

  logic [P_W-1:0] prod_r;
  mul_tag_t       tag_r;

  always_ff @(posedge clk) begin
    prod_r <= P_W'(a) * P_W'(b);
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  assign prod    = prod_r;
  assign tag_out = tag_r;

endmodule

// ===== bench/p1305_tag_checker.sv =====
// Scoreboard for the Poly1305 MAC core: predicts each tag and checks the result channel.
`timescale 1ns / 1ps
module p1305_tag_checker
  import p1305_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  output int           mismatch_count,
  output int           tags_pending
);

  localparam logic [63:0] MASK26 = 64'h3ffffff;

  typedef logic [NLIMB-1:0][63:0]       wide_t;
  typedef logic [NLIMB-1:0][LIMB_W-1:0] acc_t;

  acc_t         acc;
  logic [63:0]  key_r_lo, key_r_hi, key_s_lo, key_s_hi;
  logic [127:0] expected_tags[$];
  int           errs = 0;

  initial begin
    mismatch_count = 0;
    tags_pending   = 0;
  end

  function automatic wide_t split_limbs(logic [63:0] lo, logic [63:0] hi, logic top);
    wide_t v;
    v[0] = lo & MASK26;
    v[1] = (lo >> 26) & MASK26;
    v[2] = ((lo >> 52) | (hi << 12)) & MASK26;
    v[3] = (hi >> 14) & MASK26;
    v[4] = (hi >> 40) | (64'(top) << 24);
    return v;
  endfunction

  // carry out of the top limb wraps around as 5x (2^130 = 5 mod p)
  function automatic wide_t carry_round(wide_t d);
    wide_t       x;
    logic [63:0] c;
    x = d;
    for (int i = 0; i < 4; i++) begin
      c = x[i] >> 26;
      x[i] = x[i] & MASK26;
      x[i+1] = x[i+1] + c;
    end
    c = x[4] >> 26;
    x[4] = x[4] & MASK26;
    x[0] = x[0] + c * 5;
    return x;
  endfunction

  function automatic acc_t mul_mod(wide_t a, wide_t b);
    wide_t d, b5;
    acc_t  h;
    b5[0] = '0;
    for (int i = 1; i < 5; i++) b5[i] = b[i] * 5;
    d[0] = a[0]*b[0] + a[4]*b5[1] + a[3]*b5[2] + a[2]*b5[3] + a[1]*b5[4];
    d[1] = a[0]*b[1] + a[1]*b[0] + a[4]*b5[2] + a[3]*b5[3] + a[2]*b5[4];
    d[2] = a[0]*b[2] + a[1]*b[1] + a[2]*b[0] + a[4]*b5[3] + a[3]*b5[4];
    d[3] = a[0]*b[3] + a[1]*b[2] + a[2]*b[1] + a[3]*b[0] + a[4]*b5[4];
    d[4] = a[0]*b[4] + a[1]*b[3] + a[2]*b[2] + a[3]*b[1] + a[4]*b[0];
    d = carry_round(d);
    d = carry_round(d);
    d = carry_round(d);
    for (int i = 0; i < 5; i++) h[i] = d[i][LIMB_W-1:0];
    return h;
  endfunction

  function automatic acc_t absorb_block(acc_t h, logic [63:0] lo, logic [63:0] hi,
                                        logic [4:0] count);
    logic [4:0]  n;
    logic        top;
    logic [63:0] blo, bhi;
    wide_t       m, r;
    n   = (count > 16) ? 5'd16 : count;
    top = 1'b0;
    blo = lo;
    bhi = hi;
    if (n == 16) begin
      top = 1'b1;
    end else if (n < 8) begin
      // pad byte lands right after the data; upper half is dropped
      blo = (blo & ((64'd1 << (8 * n)) - 64'd1)) | (64'd1 << (8 * n));
      bhi = '0;
    end else begin
      bhi = (bhi & ((64'd1 << (8 * (n - 8))) - 64'd1)) | (64'd1 << (8 * (n - 8)));
    end
    if (n == 0) return h;
    m = split_limbs(blo, bhi, top);
    for (int i = 0; i < 5; i++) m[i] = m[i] + 64'(h[i]);
    r = split_limbs(key_r_lo & CLAMP_LOW, key_r_hi & CLAMP_HIGH, 1'b0);
    return mul_mod(m, r);
  endfunction

  function automatic logic [127:0] finish_tag(acc_t h);
    wide_t       g, hv;
    logic [63:0] c, t_lo, t_hi;
    logic [64:0] sum;
    c = 64'd5;
    // h + 5 overflowing 2^130 means h >= p
    for (int i = 0; i < 5; i++) begin
      g[i] = 64'(h[i]) + c;
      c = g[i] >> 26;
      g[i] = g[i] & MASK26;
    end
    for (int i = 0; i < 5; i++) hv[i] = c[0] ? g[i] : 64'(h[i]);
    t_lo = hv[0] | (hv[1] << 26) | (hv[2] << 52);
    t_hi = (hv[2] >> 12) | (hv[3] << 14) | (hv[4] << 40);
    sum  = {1'b0, t_lo} + {1'b0, key_s_lo};
    return {t_hi + key_s_hi + 64'(sum[64]), sum[63:0]};
  endfunction

  always @(posedge clk) begin : scoreboard
    logic [127:0] want;
    if (!rst_n) begin
      acc      = '0;
      key_r_lo = '0;
      key_r_hi = '0;
      key_s_lo = '0;
      key_s_hi = '0;
      expected_tags.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_tags.size() == 0) begin
          if (errs < 10) $display("unexpected tag word %h at %0t", out_tdata, $realtime);
          errs++;
        end else begin
          want = expected_tags.pop_front();
          for (int f = 0; f < 2; f++) begin
            if (out_tdata[64*f +: 64] !== want[64*f +: 64]) begin
              if (errs < 10)
                $display("%s mismatch at %0t: expected %h, got %h",
                         (f == 0) ? "tag_low" : "tag_high", $realtime,
                         want[64*f +: 64], out_tdata[64*f +: 64]);
              errs++;
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_R_LOW:  key_r_lo = cfg_wdata;
          REG_R_HIGH: key_r_hi = cfg_wdata;
          REG_S_LOW:  key_s_lo = cfg_wdata;
          REG_S_HIGH: key_s_hi = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        acc = absorb_block(acc, in_tdata[63:0], in_tdata[127:64], in_tdata[132:128]);
        if (in_tlast) begin
          expected_tags.push_back(finish_tag(acc));
          acc = '0;
        end
      end
    end
    tags_pending   <= expected_tags.size();
    mismatch_count <= errs;
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the Poly1305 MAC bench: clock, reset, key loads and message stimulus.
`timescale 1ns / 1ps
module testbench
  import p1305_pkg::*;
;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 700;
  localparam logic [63:0] ONES = '1;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         cfg_we     = 1'b0;
  logic [1:0]   cfg_index  = REG_R_LOW;
  logic [63:0]  cfg_wdata  = '0;
  logic         in_tvalid  = 1'b0;
  logic [135:0] in_tdata   = '0;
  logic         in_tlast   = 1'b0;
  logic         out_tready = 1'b0;
  logic         in_tready;
  logic         out_tvalid;
  logic [127:0] out_tdata;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  int mismatch_count;
  int tags_pending;

  always #1 clk = ~clk;

  poly1305_mac_core dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata
  );

  p1305_tag_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata,
    .mismatch_count, .tags_pending
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly random, with all-zero and all-one words mixed in
  function automatic logic [63:0] pick_word64();
    case ($urandom_range(9))
      0:       return ONES;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_key(logic [63:0] r_lo, logic [63:0] r_hi,
                          logic [63:0] s_lo, logic [63:0] s_hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_R_LOW;
    cfg_wdata <= r_lo;
    @(posedge clk);
    cfg_index <= REG_R_HIGH;
    cfg_wdata <= r_hi;
    @(posedge clk);
    cfg_index <= REG_S_LOW;
    cfg_wdata <= s_lo;
    @(posedge clk);
    cfg_index <= REG_S_HIGH;
    cfg_wdata <= s_hi;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(logic [63:0] lo, logic [63:0] hi, logic [4:0] count,
                           logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, count, hi, lo};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // hold off until every tag is out and the core has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tags_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_message(int len);
    logic [4:0] cnt;
    logic       is_last;
    for (int k = 0; k < len; k++) begin
      is_last = (k == len - 1);
      if (!is_last) begin
        cnt = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'd16;
      end else begin
        case ($urandom_range(4))
          0, 1:    cnt = 5'd16;
          2, 3:    cnt = 5'($urandom_range(15));
          default: cnt = 5'($urandom_range(17, 31));
        endcase
      end
      send_word(pick_word64(), pick_word64(), cnt, is_last);
    end
  endtask

  initial begin
    int goal;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // largest clamped r, s all ones so the final add wraps
    load_key(ONES, ONES, ONES, ONES);
    send_word(ONES, ONES, 5'd0, 1'b1);      // empty message
    send_word(ONES, ONES, 5'd16, 1'b1);
    send_word(ONES, ONES, 5'd1, 1'b1);
    send_word(ONES, ONES, 5'd7, 1'b1);
    send_word(ONES, ONES, 5'd8, 1'b1);
    send_word(ONES, ONES, 5'd9, 1'b1);
    send_word(ONES, ONES, 5'd15, 1'b1);
    send_word(ONES, ONES, 5'd17, 1'b0);     // counts above 16 act as full
    send_word(ONES, ONES, 5'd31, 1'b0);
    send_word(ONES, ONES, 5'd5, 1'b0);      // short word mid-message
    send_word(ONES, ONES, 5'd0, 1'b0);
    send_word('0, '0, 5'd16, 1'b1);

    // r = 1: accumulator climbs past p, final reduction must subtract it
    settle();
    load_key(64'd1, '0, '0, '0);
    send_word(ONES, ONES, 5'd16, 1'b0);
    send_word(ONES, ONES, 5'd16, 1'b0);
    send_word(ONES, ONES, 5'd16, 1'b1);
    send_word(ONES, ONES, 5'd0, 1'b1);

    // r = 0: tag is s whatever the data
    settle();
    load_key('0, '0, {$urandom, $urandom}, {$urandom, $urandom});
    send_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0);
    send_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd3, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 63 : 0;
      rx_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 26 : 0;
      for (int part = 0; part < 3; part++) begin
        settle();
        load_key(pick_word64(), pick_word64(), pick_word64(), pick_word64());
        goal = items_sent + RANDOM_ITEMS / 9;
        while (items_sent < goal) send_message($urandom_range(1, 6));
      end
    end

    settle();
    if (mismatch_count == 0 && tags_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
